// ----- rtl/mrae_pkg.sv -----
// Package: shared types and constants for the masked region average engine.
package mrae_pkg;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_ADDR_W = 2;
   localparam int SUM_W = 24;
   localparam int CNT_W = 17;
   localparam int MEAN_W = 16;
   localparam int COORD_W = 12;
   localparam int ACC_W = 40;
   localparam int NUM_W = ACC_W + 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WHITE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT  = 2'd3;

   localparam logic [1:0] CH_GRAY  = 2'd0;
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_GREEN = 2'd2;
   localparam logic [1:0] CH_BLUE  = 2'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_SCAN, ST_DRAIN, ST_START, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic scan;
      logic drain;
      logic div_start;
      logic div_step;
      logic out_load;
      logic out_query;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic scan_last;
      logic div_last;
   } sts_type;
endpackage

// ----- rtl/mrae_datapath.sv -----
// Datapath: pixel store, extraction, min/max, scan accumulator, divider and output register.
module mrae_datapath #(
   parameter int MAX_WIDTH  = mrae_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mrae_pkg::DEF_MAX_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic [mrae_pkg::REQ_DATA_W-1:0] req_word,
   input  logic [1:0] cfg_channel,
   input  logic cfg_white,
   input  logic [8:0] cfg_width,
   input  logic [8:0] cfg_height,
   input  mrae_pkg::cmd_type cmd,
   output mrae_pkg::sts_type sts,
   output logic [mrae_pkg::RSP_DATA_W-1:0] rsp_word,
   output logic rsp_kind
);
   import mrae_pkg::*;
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = XW + YW;
   localparam int DEPTH = 2 ** AW;
   localparam int CW = COORD_W + 1;
   localparam int DIV_STEPS = NUM_W;

   logic [8:0] mem [DEPTH];
   logic [7:0] px_x, px_y, r, g, b, rr, gg, bb, v;
   logic       mask;
   logic [12:0] gray;
   logic signed [COORD_W-1:0] lft, top, rgt, bot;

   assign px_x = req_word[7:0];
   assign px_y = req_word[15:8];
   assign r    = req_word[23:16];
   assign g    = req_word[31:24];
   assign b    = req_word[39:32];
   assign mask = req_word[40];
   assign lft  = req_word[52:41];
   assign top  = req_word[64:53];
   assign rgt  = req_word[76:65];
   assign bot  = req_word[88:77];

   assign rr = cfg_white ? ~r : r;
   assign gg = cfg_white ? ~g : g;
   assign bb = cfg_white ? ~b : b;
   assign gray = 13'(11 * rr) + 13'(16 * gg) + 13'(5 * bb);
   always_comb begin
      unique case (cfg_channel)
         CH_RED:   v = rr;
         CH_GREEN: v = gg;
         CH_BLUE:  v = bb;
         default:  v = gray[12:5];
      endcase
   end

   // store write
   logic wr_ok;
   assign wr_ok = (32'(px_x) < MAX_WIDTH) && (32'(px_y) < MAX_HEIGHT);
   logic [AW-1:0] wr_addr;
   assign wr_addr = {YW'(px_y), XW'(px_x)};

   // min/max
   logic [7:0] min_ff, max_ff, min_in, max_in;
   logic       seen_ff;
   assign min_in = (!seen_ff || v < min_ff) ? v : min_ff;
   assign max_in = (!seen_ff || v > max_ff) ? v : max_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0; max_ff <= '0; seen_ff <= 1'b0;
      end else if (cmd.load) begin
         seen_ff <= 1'b1;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // scan bounds
   logic signed [CW-1:0] x0_ff, x1_ff, y1_ff, xc_ff, yc_ff;
   logic signed [CW-1:0] wlim, hlim, x0c, y0c, x1c, y1c;
   assign wlim = (32'(cfg_width) < MAX_WIDTH) ? CW'(cfg_width) : CW'(MAX_WIDTH);
   assign hlim = (32'(cfg_height) < MAX_HEIGHT) ? CW'(cfg_height) : CW'(MAX_HEIGHT);
   assign x0c = (lft < 0) ? '0 : CW'(lft);
   assign y0c = (top < 0) ? '0 : CW'(top);
   assign x1c = (CW'(rgt) > wlim) ? wlim : CW'(rgt);
   assign y1c = (CW'(bot) > hlim) ? hlim : CW'(bot);

   logic nonempty_ff, rd_v_ff;
   logic [8:0] rd_ff;
   logic signed [CW-1:0] xn;
   assign xn = xc_ff + CW'(1);
   assign sts.scan_last = !nonempty_ff || (xn >= x1_ff && yc_ff + CW'(1) >= y1_ff);

   logic [ACC_W-1:0] sum_ff;
   logic [CNT_W+7:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) mem[wr_addr] <= {mask, v};
      rd_ff <= mem[{yc_ff[YW-1:0], xc_ff[XW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.scan && nonempty_ff;
      end
      if (cmd.setup) begin
         x0_ff <= x0c; x1_ff <= x1c; y1_ff <= y1c;
         xc_ff <= x0c; yc_ff <= y0c;
         nonempty_ff <= (x0c < x1c) && (y0c < y1c);
         sum_ff <= '0; cnt_ff <= '0;
      end else begin
         if (cmd.scan) begin
            if (xn >= x1_ff) begin
               xc_ff <= x0_ff; yc_ff <= yc_ff + CW'(1);
            end else begin
               xc_ff <= xn;
            end
         end
         if (rd_v_ff && rd_ff[8]) begin
            sum_ff <= sum_ff + ACC_W'(rd_ff[7:0]);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [NUM_W-1:0] q_ff;
   logic [CNT_W+8:0] rem_ff;
   logic [5:0] step_ff;
   logic [CNT_W+9:0] trial;
   assign trial = {rem_ff, q_ff[NUM_W-1]} - (CNT_W+10)'(cnt_ff);
   assign sts.div_last = (step_ff == 6'(DIV_STEPS - 1));
   assign sts.empty = (cnt_ff == '0);
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         q_ff <= NUM_W'({sum_ff, 8'd0}) + NUM_W'(cnt_ff >> 1);
         rem_ff <= '0; step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
         if (!trial[CNT_W+9]) begin
            rem_ff <= trial[CNT_W+8:0];
            q_ff <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[CNT_W+7:0], q_ff[NUM_W-1]};
            q_ff <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   // output register
   logic [RSP_DATA_W-1:0] out_ff;
   logic kind_ff;
   logic [SUM_W-1:0] s_sat;
   logic [CNT_W-1:0] c_sat;
   logic [MEAN_W-1:0] m_sat;
   assign s_sat = (sum_ff > ACC_W'({SUM_W{1'b1}})) ? '1 : sum_ff[SUM_W-1:0];
   assign c_sat = (cnt_ff > (CNT_W+8)'({CNT_W{1'b1}})) ? '1 : cnt_ff[CNT_W-1:0];
   assign m_sat = sts.empty ? '0 : ((q_ff > NUM_W'(16'hFFFF)) ? '1 : q_ff[MEAN_W-1:0]);
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= {6'd0, 1'b0, 16'd0, 17'd0, 24'd0, max_in, min_in};
         kind_ff <= CMD_LOAD;
      end else if (cmd.out_query) begin
         out_ff <= {6'd0, sts.empty, m_sat, c_sat, s_sat, max_ff, min_ff};
         kind_ff <= CMD_QUERY;
      end
   end
   assign rsp_word = out_ff;
   assign rsp_kind = kind_ff;
endmodule

// ----- rtl/mrae_ctrl.sv -----
// Controller: sequences loads, rectangle scans, division and the result handshake.
module mrae_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_cmd,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  mrae_pkg::sts_type sts,
   output mrae_pkg::cmd_type cmd
);
   import mrae_pkg::*;
   state_type state_ff, state_in;
   logic full_ff, full_in;
   logic take, pop;

   assign pop  = full_ff && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && (!full_ff || rsp_tready);
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = full_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take && req_cmd == CMD_QUERY) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_SCAN;
         ST_SCAN:  if (sts.scan_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (sts.div_last) state_in = ST_OUT;
         ST_OUT:   if (!full_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = take && req_cmd == CMD_LOAD;
            cmd.out_load = cmd.load;
            cmd.setup = take && req_cmd == CMD_QUERY;
         end
         ST_SCAN:  cmd.scan = 1'b1;
         ST_START: cmd.div_start = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_OUT:   cmd.out_query = !full_ff || rsp_tready;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      full_in = full_ff;
      if (pop) full_in = 1'b0;
      if (cmd.out_load || cmd.out_query) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff <= full_in;
      end
   end
endmodule

// ----- rtl/masked_region_average_engine_unit.sv -----
// Top level: masked region average engine with stream ports and register writes.
// Loads take one word per cycle while the output register is empty or being drained;
// the acknowledgement is registered at the accepting edge in a one-word output register.
// A query first reads its clipped rectangle, one stored pixel per cycle from the
// store, then a 48-step restoring divider forms the rounded 8.8 mean; no new request
// is accepted until the query result has been loaded into the output register.
// The store has no reset; query only written pixels.
module masked_region_average_engine_unit #(
   parameter int MAX_WIDTH  = mrae_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mrae_pkg::DEF_MAX_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pixel_x, pixel_y, red, green, blue, mask_on, rect_left, rect_top,
   // rect_right, rect_bottom, zero fill
   input  logic [mrae_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // color_min, color_max, pixel_sum, pixel_count, mean_value,
   // empty_region, zero fill
   output logic [mrae_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind
   output logic rsp_tuser,
   input  logic csr_we,
   input  logic [mrae_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mrae_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mrae_pkg::*;
   logic [1:0] ch_ff;
   logic white_ff;
   logic [8:0] w_ff, h_ff;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= CH_GRAY; white_ff <= 1'b1; w_ff <= 9'd256; h_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CHANNEL: ch_ff <= csr_wdata[1:0];
            CSR_WHITE:   white_ff <= csr_wdata[0];
            CSR_WIDTH:   w_ff <= csr_wdata;
            CSR_HEIGHT:  h_ff <= csr_wdata;
            default:     ch_ff <= ch_ff;
         endcase
      end
   end

   mrae_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_cmd(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   mrae_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .req_word(req_tdata), .cfg_channel(ch_ff),
      .cfg_white(white_ff), .cfg_width(w_ff), .cfg_height(h_ff), .cmd(cmd),
      .sts(sts), .rsp_word(rsp_tdata), .rsp_kind(rsp_tuser)
   );

   a_ack_kind: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid && rsp_tuser == CMD_LOAD) else $error("ack kind");
   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[73] |-> rsp_tdata[72:57] == '0 && rsp_tdata[56:40] == '0)
      else $error("empty mean");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.setup |=> !req_tready) else $error("busy");
endmodule

// ----- dv/testbench.sv -----
// Testbench for the masked region average engine: random stream traffic and a local model.
`timescale 1ns / 1ps
module testbench;
   import mrae_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int FILL = 16;

   typedef struct {
      logic        cmd;
      logic [7:0]  px;
      logic [7:0]  py;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        mask_on;
      logic [11:0] left;
      logic [11:0] top;
      logic [11:0] right;
      logic [11:0] bottom;
   } word_in_type;

   typedef struct {
      logic        kind;
      logic [7:0]  cmin;
      logic [7:0]  cmax;
      logic [23:0] sum;
      logic [16:0] count;
      logic [15:0] mean;
      logic        empty;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   masked_region_average_engine_unit dut (.*);

   always #4 clock = ~clock;

   // model state
   logic [8:0] pix_mem [0:65535];
   logic [7:0] run_min, run_max;
   logic       have_pixel;
   logic [1:0] m_channel;
   logic       m_white;
   logic [8:0] m_width, m_height;

   answer_type expected_answers [$];
   int errors = 0;
   int cycles = 0;
   bit no_idle = 0;
   int hold_request = 0;

   function automatic logic [7:0] pick_value(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [12:0] mix;
      if (m_white) begin
         r = 8'd255 - r; g = 8'd255 - g; b = 8'd255 - b;
      end
      case (m_channel)
         CH_RED:   return r;
         CH_GREEN: return g;
         CH_BLUE:  return b;
         default: begin
            mix = 13'd11 * r + 13'd16 * g + 13'd5 * b;
            return mix[12:5];
         end
      endcase
   endfunction

   function automatic answer_type compute_answer(word_in_type w);
      answer_type a;
      logic [7:0] v;
      int x0, y0, x1, y1, wl, hl;
      longint s, c, mn;
      s = 0; c = 0; mn = 0;
      if (w.cmd == CMD_LOAD) begin
         v = pick_value(w.red, w.green, w.blue);
         pix_mem[{w.py, w.px}] = {w.mask_on, v};
         if (!have_pixel) begin
            run_min = v; run_max = v; have_pixel = 1;
         end else begin
            if (v < run_min) run_min = v;
            if (v > run_max) run_max = v;
         end
      end else begin
         wl = (m_width < 256) ? m_width : 256;
         hl = (m_height < 256) ? m_height : 256;
         x0 = $signed(w.left); y0 = $signed(w.top);
         x1 = $signed(w.right); y1 = $signed(w.bottom);
         if (x0 < 0) x0 = 0;
         if (y0 < 0) y0 = 0;
         if (x1 > wl) x1 = wl;
         if (y1 > hl) y1 = hl;
         for (int x = x0; x < x1; x++)
            for (int y = y0; y < y1; y++)
               if (pix_mem[y * 256 + x][8]) begin
                  s += pix_mem[y * 256 + x][7:0];
                  c++;
               end
         if (c != 0) mn = (s * 256 + c / 2) / c;
         if (mn > 65535) mn = 65535;
         if (s > 24'hFFFFFF) s = 24'hFFFFFF;
      end
      a.kind = w.cmd;
      a.cmin = run_min;
      a.cmax = run_max;
      a.sum = s[23:0];
      a.count = (c > 17'h1FFFF) ? 17'h1FFFF : c[16:0];
      a.mean = mn[15:0];
      a.empty = (w.cmd == CMD_QUERY && c == 0);
      return a;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 19);
      if (r < 13) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(word_in_type w);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, w.bottom, w.right, w.top, w.left, w.mask_on,
                    w.blue, w.green, w.red, w.py, w.px};
      req_tuser <= w.cmd;
      do @(posedge clock); while (!req_tready);
      expected_answers.insert(expected_answers.size(), compute_answer(w));
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_answers.size() == 0);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CHANNEL: m_channel = val[1:0];
         CSR_WHITE:   m_white = val[0];
         CSR_WIDTH:   m_width = val;
         default:     m_height = val;
      endcase
   endtask

   function automatic word_in_type load_word(int x, int y, logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic m);
      word_in_type w = '{default: '0};
      w.cmd = CMD_LOAD; w.px = 8'(x); w.py = 8'(y);
      w.red = r; w.green = g; w.blue = b; w.mask_on = m;
      w.left = 12'($urandom); w.top = 12'($urandom);
      w.right = 12'($urandom); w.bottom = 12'($urandom);
      return w;
   endfunction

   function automatic word_in_type query_word(int l, int t, int r, int b);
      word_in_type w = '{default: '0};
      w.cmd = CMD_QUERY;
      w.px = 8'($urandom); w.py = 8'($urandom); w.red = 8'($urandom);
      w.green = 8'($urandom); w.blue = 8'($urandom); w.mask_on = 1'($urandom);
      w.left = 12'(l); w.top = 12'(t); w.right = 12'(r); w.bottom = 12'(b);
      return w;
   endfunction

   function automatic word_in_type random_load(int span);
      return load_word($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                       8'($urandom), 8'($urandom), 8'($urandom),
                       $urandom_range(0, 3) != 0);
   endfunction

   function automatic int rand_coord();
      int r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(0, 24) - 4;
      if (r < 9) return $urandom_range(0, 4095) - 2048;
      return ($urandom_range(0, 1) != 0) ? 2047 : -2048;
   endfunction

   task automatic test_before_load();
      send_word(query_word(5, 5, 5, 5));
      send_word(query_word(2047, 2047, -2048, -2048));
   endtask

   task automatic fill_region();
      for (int y = 0; y < FILL; y++)
         for (int x = 0; x < FILL; x++)
            send_word(random_load(256 - 255 + x) );
   endtask

   task automatic fill_grid();
      for (int y = 0; y < FILL; y++)
         for (int x = 0; x < FILL; x++)
            send_word(load_word(x, y, 8'($urandom), 8'($urandom), 8'($urandom),
                                $urandom_range(0, 3) != 0));
   endtask

   task automatic test_directed();
      send_word(load_word(255, 255, 8'd0, 8'd0, 8'd0, 1'b1));
      send_word(load_word(0, 0, 8'd255, 8'd255, 8'd255, 1'b1));
      send_word(load_word(1, 0, 8'd255, 8'd0, 8'd0, 1'b0));
      send_word(load_word(0, 1, 8'd0, 8'd255, 8'd0, 1'b1));
      send_word(load_word(1, 1, 8'd0, 8'd0, 8'd255, 1'b1));
      write_reg(CSR_WIDTH, 9'd2);
      write_reg(CSR_HEIGHT, 9'd2);
      send_word(query_word(-2048, -2048, 2047, 2047));
      send_word(query_word(0, 0, 1, 1));
      send_word(query_word(1, 1, 0, 0));
      send_word(query_word(1, 0, 2, 2));
      write_reg(CSR_WHITE, 9'd0);
      for (int ch = 0; ch < 4; ch++) begin
         write_reg(CSR_CHANNEL, 9'(ch));
         send_word(load_word(0, 0, 8'hA5, 8'h5A, 8'hFF, 1'b1));
         send_word(load_word(1, 1, 8'h12, 8'h34, 8'h56, 1'b1));
         send_word(query_word(-1, -1, 3, 3));
      end
      // zero-size image covers nothing
      write_reg(CSR_WIDTH, 9'd0);
      send_word(query_word(-2048, -2048, 2047, 2047));
      write_reg(CSR_WIDTH, 9'h1FF);
      write_reg(CSR_HEIGHT, 9'd0);
      send_word(query_word(0, 0, 2047, 2047));
   endtask

   task automatic test_full_row();
      write_reg(CSR_CHANNEL, 9'($urandom_range(0, 3)));
      write_reg(CSR_WHITE, 9'($urandom_range(0, 1)));
      for (int x = 0; x < 256; x++)
         send_word(load_word(x, 0, 8'($urandom), 8'($urandom), 8'($urandom),
                             $urandom_range(0, 3) != 0));
      write_reg(CSR_WIDTH, 9'd256);
      write_reg(CSR_HEIGHT, 9'd1);
      send_word(query_word(-2048, -2048, 2047, 2047));
      send_word(query_word(100, 0, 200, 1));
      write_reg(CSR_WIDTH, 9'd300);
      send_word(query_word(0, 0, 2047, 5));
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_CHANNEL, 9'((phase < 4) ? phase : $urandom_range(0, 3)));
         write_reg(CSR_WHITE, 9'(phase[0] ^ phase[2]));
         write_reg(CSR_WIDTH,
                   9'((phase == 0) ? 1 : (phase == 1) ? FILL : $urandom_range(1, FILL)));
         write_reg(CSR_HEIGHT,
                   9'((phase == 0) ? FILL : (phase == 1) ? 1 : $urandom_range(1, FILL)));
         no_idle = (phase == 3);
         if (phase == 5) hold_request = 400;
         for (int i = 0; i < 110; i++) begin
            if ($urandom_range(0, 9) < 6)
               send_word(($urandom_range(0, 3) == 0) ?
                         load_word($urandom, $urandom, 8'($urandom), 8'($urandom),
                                   8'($urandom), 1'($urandom_range(0, 1))) :
                         random_load(FILL));
            else
               send_word(query_word(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
         end
         no_idle = 0;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      answer_type got, exp_a;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.cmin = rsp_tdata[7:0];
         got.cmax = rsp_tdata[15:8];
         got.sum = rsp_tdata[39:16];
         got.count = rsp_tdata[56:40];
         got.mean = rsp_tdata[72:57];
         got.empty = rsp_tdata[73];
         if (expected_answers.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            exp_a = expected_answers.pop_front();
            if (got.kind !== exp_a.kind) begin
               $error("result_kind exp %0h got %0h", exp_a.kind, got.kind); errors++;
            end
            if (got.cmin !== exp_a.cmin) begin
               $error("color_min exp %0h got %0h", exp_a.cmin, got.cmin); errors++;
            end
            if (got.cmax !== exp_a.cmax) begin
               $error("color_max exp %0h got %0h", exp_a.cmax, got.cmax); errors++;
            end
            if (got.sum !== exp_a.sum) begin
               $error("pixel_sum exp %0h got %0h", exp_a.sum, got.sum); errors++;
            end
            if (got.count !== exp_a.count) begin
               $error("pixel_count exp %0h got %0h", exp_a.count, got.count); errors++;
            end
            if (got.mean !== exp_a.mean) begin
               $error("mean_value exp %0h got %0h", exp_a.mean, got.mean); errors++;
            end
            if (got.empty !== exp_a.empty) begin
               $error("empty_region exp %0h got %0h", exp_a.empty, got.empty); errors++;
            end
         end
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver backpressure
   int stall_left = 0;
   always @(negedge clock) begin
      int r;
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 19);
         if (r < 14) rsp_tready <= 1'b1;
         else begin
            rsp_tready <= 1'b0;
            if (r == 19) stall_left = $urandom_range(8, 40);
            else stall_left = $urandom_range(0, 2);
         end
      end
   end

   initial begin
      run_min = 0; run_max = 0; have_pixel = 0;
      m_channel = CH_GRAY; m_white = 1; m_width = 256; m_height = 256;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_before_load();
      test_directed();
      fill_grid();
      test_random();
      test_full_row();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_answers.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
